// File: rtl/core/seg_pkg.sv
package seg_pkg;

    // Coordinate width and the widths of the exact intermediate terms.
    localparam int CW  = 16;          // coordinate
    localparam int AW  = CW + 1;      // line coefficient a, b
    localparam int PW  = 2 * CW;      // coordinate product
    localparam int CCW = 2 * CW + 1;  // line coefficient c, side terms
    localparam int SW  = 2 * CW + 3;  // side value
    localparam int DW  = 2 * CW + 3;  // determinant and its magnitude
    localparam int NW  = 3 * CW + 3;  // numerator
    localparam int MW  = 3 * CW + 4;  // rounded numerator magnitude
    localparam int QB  = CW + 1;      // quotient bits, one per divider cell

    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_PARALLEL = 2'd1,
        KIND_FOUND    = 2'd2
    } kind_t;

    // One long division lane: partial remainder, dividend bits still to
    // consume (quotient bits shift in from the bottom), overflow and sign.
    typedef struct packed {
        logic [DW-1:0] rem;
        logic [QB-1:0] bits;
        logic          ovf;
        logic          neg;
    } div_lane_t;

    typedef struct packed {
        div_lane_t     x;
        div_lane_t     y;
        logic [DW-1:0] dm;
        kind_t         kind;
    } div_item_t;

    // One restoring division step: bring down the next dividend bit.
    function automatic div_lane_t div_step(div_lane_t l, logic [DW-1:0] dm);
        logic [DW:0] t;
        logic        q;
        div_lane_t   r;
        t = {l.rem, l.bits[QB-1]};
        q = (t >= {1'b0, dm});
        r = l;
        r.rem  = q ? DW'(t - {1'b0, dm}) : t[DW-1:0];
        r.bits = {l.bits[QB-2:0], q};
        return r;
    endfunction

endpackage

// File: rtl/core/seg_front.sv
module seg_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [seg_pkg::CW-1:0]    x1,
    input  logic signed [seg_pkg::CW-1:0]    y1,
    input  logic signed [seg_pkg::CW-1:0]    x2,
    input  logic signed [seg_pkg::CW-1:0]    y2,
    input  logic signed [seg_pkg::CW-1:0]    x3,
    input  logic signed [seg_pkg::CW-1:0]    y3,
    input  logic signed [seg_pkg::CW-1:0]    x4,
    input  logic signed [seg_pkg::CW-1:0]    y4,
    output logic                             out_valid,
    output seg_pkg::div_item_t               out_item
);

    localparam int AW  = seg_pkg::AW;
    localparam int PW  = seg_pkg::PW;
    localparam int CCW = seg_pkg::CCW;
    localparam int SW  = seg_pkg::SW;
    localparam int DW  = seg_pkg::DW;
    localparam int NW  = seg_pkg::NW;
    localparam int MW  = seg_pkg::MW;
    localparam int QB  = seg_pkg::QB;

    logic [5:0] valid_reg;

    // Stage 1: line coefficients and all first level products.
    logic signed [AW-1:0]   a1_w, b1_w, a2_w, b2_w;
    logic signed [AW-1:0]   a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [PW-1:0]   p21_reg, p12_reg, p43_reg, p34_reg;
    logic signed [CCW-1:0]  t13a_reg, t13b_reg, t14a_reg, t14b_reg;
    logic signed [CCW-1:0]  t21a_reg, t21b_reg, t22a_reg, t22b_reg;
    logic signed [2*AW-1:0] d1_reg, d2_reg;

    assign a1_w = AW'(y2) - AW'(y1);
    assign b1_w = AW'(x1) - AW'(x2);
    assign a2_w = AW'(y4) - AW'(y3);
    assign b2_w = AW'(x3) - AW'(x4);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg   <= a1_w;
            b1_reg   <= b1_w;
            a2_reg   <= a2_w;
            b2_reg   <= b2_w;
            p21_reg  <= PW'(x2) * PW'(y1);
            p12_reg  <= PW'(x1) * PW'(y2);
            p43_reg  <= PW'(x4) * PW'(y3);
            p34_reg  <= PW'(x3) * PW'(y4);
            t13a_reg <= CCW'(a1_w) * CCW'(x3);
            t13b_reg <= CCW'(b1_w) * CCW'(y3);
            t14a_reg <= CCW'(a1_w) * CCW'(x4);
            t14b_reg <= CCW'(b1_w) * CCW'(y4);
            t21a_reg <= CCW'(a2_w) * CCW'(x1);
            t21b_reg <= CCW'(b2_w) * CCW'(y1);
            t22a_reg <= CCW'(a2_w) * CCW'(x2);
            t22b_reg <= CCW'(b2_w) * CCW'(y2);
            d1_reg   <= (2*AW)'(a1_w) * (2*AW)'(b2_w);
            d2_reg   <= (2*AW)'(a2_w) * (2*AW)'(b1_w);
        end
    end

    // Stage 2: c terms, side values of each endpoint, determinant.
    logic signed [SW-1:0]  s13_w, s14_w, s21_w, s22_w;
    logic                  same1_w, same2_w;
    logic signed [CCW-1:0] c1_reg, c2_reg;
    logic signed [DW-1:0]  den_reg;
    logic                  fail_reg;
    logic signed [AW-1:0]  a1b_reg, b1b_reg, a2b_reg, b2b_reg;

    assign s13_w = SW'(t13a_reg) + SW'(t13b_reg) + SW'(p21_reg) - SW'(p12_reg);
    assign s14_w = SW'(t14a_reg) + SW'(t14b_reg) + SW'(p21_reg) - SW'(p12_reg);
    assign s21_w = SW'(t21a_reg) + SW'(t21b_reg) + SW'(p43_reg) - SW'(p34_reg);
    assign s22_w = SW'(t22a_reg) + SW'(t22b_reg) + SW'(p43_reg) - SW'(p34_reg);

    // A zero side value never counts as the same side.
    assign same1_w = (s13_w != '0) && (s14_w != '0) && (s13_w[SW-1] == s14_w[SW-1]);
    assign same2_w = (s21_w != '0) && (s22_w != '0) && (s21_w[SW-1] == s22_w[SW-1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg   <= CCW'(p21_reg) - CCW'(p12_reg);
            c2_reg   <= CCW'(p43_reg) - CCW'(p34_reg);
            den_reg  <= DW'(d1_reg) - DW'(d2_reg);
            fail_reg <= same1_w || same2_w;
            a1b_reg  <= a1_reg;
            b1b_reg  <= b1_reg;
            a2b_reg  <= a2_reg;
            b2b_reg  <= b2_reg;
        end
    end

    // Stage 3: numerator products, result kind, determinant magnitude.
    logic signed [NW-1:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic [DW-1:0]        dm3_reg;
    logic                 dneg3_reg;
    seg_pkg::kind_t       kind3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg    <= NW'(b1b_reg) * NW'(c2_reg);
            m2_reg    <= NW'(b2b_reg) * NW'(c1_reg);
            m3_reg    <= NW'(a2b_reg) * NW'(c1_reg);
            m4_reg    <= NW'(a1b_reg) * NW'(c2_reg);
            dm3_reg   <= den_reg[DW-1] ? DW'(-den_reg) : DW'(den_reg);
            dneg3_reg <= den_reg[DW-1];
            if (fail_reg)
                kind3_reg <= seg_pkg::KIND_NONE;
            else if (den_reg == '0)
                kind3_reg <= seg_pkg::KIND_PARALLEL;
            else
                kind3_reg <= seg_pkg::KIND_FOUND;
        end
    end

    // Stage 4: numerators.
    logic signed [NW-1:0] nx_reg, ny_reg;
    logic [DW-1:0]        dm4_reg;
    logic                 dneg4_reg;
    seg_pkg::kind_t       kind4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg    <= m1_reg - m2_reg;
            ny_reg    <= m3_reg - m4_reg;
            dm4_reg   <= dm3_reg;
            dneg4_reg <= dneg3_reg;
            kind4_reg <= kind3_reg;
        end
    end

    // Stage 5: numerator magnitude plus half the divisor for rounding.
    logic [MW-1:0]  nxm_w, nym_w;
    logic [MW-1:0]  nx5_reg, ny5_reg;
    logic           negx5_reg, negy5_reg;
    logic [DW-1:0]  dm5_reg;
    seg_pkg::kind_t kind5_reg;

    assign nxm_w = nx_reg[NW-1] ? MW'(-nx_reg) : MW'(nx_reg);
    assign nym_w = ny_reg[NW-1] ? MW'(-ny_reg) : MW'(ny_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx5_reg   <= nxm_w + MW'(dm4_reg >> 1);
            ny5_reg   <= nym_w + MW'(dm4_reg >> 1);
            negx5_reg <= nx_reg[NW-1] != dneg4_reg;
            negy5_reg <= ny_reg[NW-1] != dneg4_reg;
            dm5_reg   <= dm4_reg;
            kind5_reg <= kind4_reg;
        end
    end

    // Stage 6: split dividend into initial remainder and low bits, flag overflow.
    seg_pkg::div_item_t item_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg.x.rem  <= nx5_reg[MW-1:QB];
            item_reg.x.bits <= nx5_reg[QB-1:0];
            item_reg.x.ovf  <= nx5_reg[MW-1:QB] >= dm5_reg;
            item_reg.x.neg  <= negx5_reg;
            item_reg.y.rem  <= ny5_reg[MW-1:QB];
            item_reg.y.bits <= ny5_reg[QB-1:0];
            item_reg.y.ovf  <= ny5_reg[MW-1:QB] >= dm5_reg;
            item_reg.y.neg  <= negy5_reg;
            item_reg.dm     <= dm5_reg;
            item_reg.kind   <= kind5_reg;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[4:0], in_valid};
    end

    assign out_valid = valid_reg[5];
    assign out_item  = item_reg;

endmodule

// File: rtl/core/seg_div_cell.sv
module seg_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  seg_pkg::div_item_t in_item,
    output logic               out_valid,
    output seg_pkg::div_item_t out_item
);

    logic               valid_reg;
    seg_pkg::div_item_t item_reg;
    seg_pkg::div_item_t item_next;

    // One quotient bit for each of the two lanes, sharing the divisor.
    always_comb
    begin
        item_next   = in_item;
        item_next.x = seg_pkg::div_step(in_item.x, in_item.dm);
        item_next.y = seg_pkg::div_step(in_item.y, in_item.dm);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// File: rtl/core/segment_intersection.sv
// Segment intersection test with rounded crossing point.
// Input channel: in_valid/in_ready carry one beat holding both segments,
// A from (a_start_x, a_start_y) to (a_end_x, a_end_y) and B likewise.
// Output channel: out_valid/out_ready carry one beat per input beat:
// kind (0 none, 1 parallel or collinear, 2 found) and the crossing point,
// rounded half away from zero and saturated; the point reads 0 unless kind is 2.
// An accepted input beat reaches the output beat through the front stages of
// line equations, side tests, determinant and numerators, one divider cell per
// quotient bit (17 cells), then one output register.
// Throughput is one beat per cycle; the divider is a row of cells, each
// producing one quotient bit of both coordinates and handing on its remainder.
// The whole pipeline advances together: when the output beat is stalled by
// out_ready, in_ready drops and every stage holds its contents.
// Reset clears all valid bits; no output beat is shown until new input arrives.
module segment_intersection (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [seg_pkg::CW-1:0] a_start_x,
    input  logic signed [seg_pkg::CW-1:0] a_start_y,
    input  logic signed [seg_pkg::CW-1:0] a_end_x,
    input  logic signed [seg_pkg::CW-1:0] a_end_y,
    input  logic signed [seg_pkg::CW-1:0] b_start_x,
    input  logic signed [seg_pkg::CW-1:0] b_start_y,
    input  logic signed [seg_pkg::CW-1:0] b_end_x,
    input  logic signed [seg_pkg::CW-1:0] b_end_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    kind,
    output logic signed [seg_pkg::CW-1:0] cross_x,
    output logic signed [seg_pkg::CW-1:0] cross_y
);

    localparam int CW = seg_pkg::CW;
    localparam int QB = seg_pkg::QB;

    logic                 en;
    logic [QB:0]          valid_chain;
    seg_pkg::div_item_t   item_chain [QB+1];
    logic                 out_valid_reg;
    seg_pkg::kind_t       kind_reg;
    logic signed [CW-1:0] cross_x_reg, cross_y_reg;

    // Pipeline moves whenever the output register is empty or being drained.
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    seg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .x1        (a_start_x),
        .y1        (a_start_y),
        .x2        (a_end_x),
        .y2        (a_end_y),
        .x3        (b_start_x),
        .y3        (b_start_y),
        .x4        (b_end_x),
        .y4        (b_end_y),
        .out_valid (valid_chain[0]),
        .out_item  (item_chain[0])
    );

    // Divider row: one cell per quotient bit.
    for (genvar i = 0; i < QB; i++)
    begin : g_cell
        seg_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (valid_chain[i]),
            .in_item   (item_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_item  (item_chain[i+1])
        );
    end

    // Saturate the quotient magnitude and apply the sign.
    function automatic logic [CW-1:0] round_sat(seg_pkg::div_lane_t l);
        logic [QB-1:0] lim;
        logic [QB-1:0] m;
        lim = l.neg ? (QB'(1) << (CW - 1)) : ((QB'(1) << (CW - 1)) - QB'(1));
        m   = (l.ovf || (l.bits > lim)) ? lim : l.bits;
        return l.neg ? CW'(-m) : m[CW-1:0];
    endfunction

    // Output register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_reg <= item_chain[QB].kind;
            if (item_chain[QB].kind == seg_pkg::KIND_FOUND)
            begin
                cross_x_reg <= round_sat(item_chain[QB].x);
                cross_y_reg <= round_sat(item_chain[QB].y);
            end
            else
            begin
                cross_x_reg <= '0;
                cross_y_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= valid_chain[QB];
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign cross_x   = cross_x_reg;
    assign cross_y   = cross_y_reg;

    // A point is only reported for a found crossing.
    a_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != seg_pkg::KIND_FOUND) |-> (cross_x == '0) && (cross_y == '0))
        else $error("crossing point not zero for a non-found result");

    // A stall freezes the valid chain from the front end through the divider row.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_chain))
        else $error("pipeline moved during an output stall");

    // An output beat appears only when the last divider cell held one.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(valid_chain[QB]))
        else $error("output beat without a source");

endmodule
